[hw/rtl/weighted_category_sampler_macros.svh]
// Assertion macros for the sampler RTL.
`ifndef WEIGHTED_CATEGORY_SAMPLER_MACROS_SVH
`define WEIGHTED_CATEGORY_SAMPLER_MACROS_SVH

// Condition that must hold at every rising clock edge outside reset.
`define WCS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sampler check failed");

// Implication checked in the same cycle outside reset.
`define WCS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sampler check failed");

`endif

[hw/rtl/wcs_pkg.sv]
// Types and constants of the weighted category sampler.
package wcs_pkg;

    localparam int MAX_CATEGORIES = 64;
    localparam int WEIGHT_BITS    = 16;
    localparam int UNIFORM_BITS   = 16;
    localparam int CNT_W          = $clog2(MAX_CATEGORIES);
    localparam int ACC_W          = WEIGHT_BITS + CNT_W;
    localparam int CAT_W          = 7;
    localparam int IDX_W          = 6;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WITH_REPL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CAT_COUNT = CFG_IDX_W'(1);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    typedef struct packed {
        logic        func;
        logic [5:0]  weight_index;
        logic [15:0] weight_value;
        logic [15:0] uniform_fraction;
    } t_in_item;

    typedef struct packed {
        logic [6:0] category;
        logic       pool_empty;
    } t_out_item;

    typedef struct packed {
        logic                   shift;
        logic                   load;
        logic [IDX_W-1:0]       load_idx;
        logic [WEIGHT_BITS-1:0] load_data;
        logic [WEIGHT_BITS-1:0] tail_data;
    } t_ring_ctrl;

endpackage

[hw/rtl/wcs_cell.sv]
// One weight cell of the rotating ring.
module wcs_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic [wcs_pkg::WEIGHT_BITS-1:0] i_shift_data,
    input  logic                           i_load,
    input  logic [wcs_pkg::WEIGHT_BITS-1:0] i_load_data,
    output logic [wcs_pkg::WEIGHT_BITS-1:0] o_weight
);
    import wcs_pkg::*;

    logic [WEIGHT_BITS-1:0] r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_shift) begin
            r_weight <= i_shift_data;
        end else if (i_load) begin
            r_weight <= i_load_data;
        end
    end

    assign o_weight = r_weight;
endmodule

[hw/rtl/wcs_ring.sv]
// Ring of weight cells that rotates toward the head once per cycle during a pass.
module wcs_ring (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wcs_pkg::t_ring_ctrl             i_ctrl,
    output logic [wcs_pkg::WEIGHT_BITS-1:0] o_head
);
    import wcs_pkg::*;

    logic [WEIGHT_BITS-1:0] w_weight [MAX_CATEGORIES];

    for (genvar i = 0; i < MAX_CATEGORIES; i++) begin : g_cell
        logic [WEIGHT_BITS-1:0] w_next;
        logic                   w_load;

        // The tail cell takes the value that leaves the head, possibly cleared.
        if (i == MAX_CATEGORIES - 1) begin : g_tail
            assign w_next = i_ctrl.tail_data;
        end else begin : g_body
            assign w_next = w_weight[i+1];
        end

        assign w_load = i_ctrl.load && (i_ctrl.load_idx == IDX_W'(i));

        wcs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (i_ctrl.shift),
            .i_shift_data (w_next),
            .i_load       (w_load),
            .i_load_data  (i_ctrl.load_data),
            .o_weight     (w_weight[i])
        );
    end

    assign o_head = w_weight[0];
endmodule

[hw/rtl/weighted_category_sampler.sv]
// Draw steps: when a load or a category_count write left the total stale, a ring pass
// rebuilds it first; then come a multiply step, a scan pass over the ring of 64 weight
// cells, which rotates one slot per cycle during a pass, and a result step. On an empty
// pool the scan pass is skipped. Loads write their cell when accepted. One item is in work
// at a time; a stalled result keeps the input stalled.
// Reset (synchronous, active low) clears weights and total, keep-drawn flag 1, count 64.
`include "weighted_category_sampler_macros.svh"

module weighted_category_sampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  wcs_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output wcs_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wcs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wcs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TOTAL = 5'b00010,
        S_MUL   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                  r_state;
    logic                    r_with_repl;
    logic [CAT_W-1:0]        r_cat_count;
    logic                    r_stale;
    logic [ACC_W-1:0]        r_total;
    logic [CNT_W-1:0]        r_k;
    logic [ACC_W-1:0]        r_acc;
    logic [ACC_W-1:0]        r_q;
    logic [UNIFORM_BITS-1:0] r_u;
    logic                    r_found;
    logic [CAT_W-1:0]        r_cat;
    logic [WEIGHT_BITS-1:0]  r_found_w;
    logic                    r_empty;
    logic                    r_out_valid;
    t_out_item               r_out_item;

    logic                            w_in_acc;
    logic                            w_cfg_acc;
    logic                            w_count_wr;
    logic [CNT_W:0]                  w_n_eff;
    logic                            w_in_use;
    logic [WEIGHT_BITS-1:0]          w_head;
    logic [ACC_W-1:0]                w_acc_next;
    logic                            w_hit;
    logic                            w_last;
    logic [UNIFORM_BITS+ACC_W-1:0]   w_product;
    logic                            w_out_free;
    t_ring_ctrl                      w_ring;

    assign o_in_stall  = (r_state != S_IDLE);
    // Register writes are taken only while no draw is in work.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_count_wr  = w_cfg_acc && (i_cfg_index == REG_CAT_COUNT);

    // A count above the number of cells acts as the number of cells.
    assign w_n_eff = (r_cat_count > CAT_W'(MAX_CATEGORIES))
                   ? (CNT_W+1)'(MAX_CATEGORIES) : (CNT_W+1)'(r_cat_count);
    assign w_in_use   = {1'b0, r_k} < w_n_eff;
    assign w_acc_next = r_acc + (w_in_use ? ACC_W'(w_head) : ACC_W'(0));
    assign w_last     = (r_k == CNT_W'(MAX_CATEGORIES - 1));
    // First slot whose running sum passes the scaled target is the drawn one.
    assign w_hit      = (r_state == S_SCAN) && w_in_use && !r_found && (w_acc_next > r_q);
    assign w_product  = (UNIFORM_BITS+ACC_W)'(r_u) * (UNIFORM_BITS+ACC_W)'(r_total);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_ring.shift     = (r_state == S_TOTAL) || (r_state == S_SCAN);
        w_ring.load      = w_in_acc && (i_in_item.func == FUNC_LOAD);
        w_ring.load_idx  = i_in_item.weight_index;
        w_ring.load_data = i_in_item.weight_value[WEIGHT_BITS-1:0];
        w_ring.tail_data = (w_hit && !r_with_repl) ? '0 : w_head;
    end

    wcs_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ring),
        .o_head  (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_with_repl <= 1'b1;
            r_cat_count <= CAT_W'(MAX_CATEGORIES);
            r_stale     <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_acc && (i_cfg_index == REG_WITH_REPL)) begin
                r_with_repl <= i_cfg_data[0];
            end
            if (w_count_wr) begin
                r_cat_count <= i_cfg_data[CAT_W-1:0];
            end
            if (w_count_wr || w_ring.load) begin
                r_stale <= 1'b1;
            end else if ((r_state == S_TOTAL) && w_last) begin
                r_stale <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_in_item.func == FUNC_DRAW)) begin
                        r_state <= (r_stale || w_count_wr) ? S_TOTAL : S_MUL;
                    end
                end
                S_TOTAL: begin
                    if (w_last) begin
                        r_total <= w_acc_next;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= (r_total == '0) ? S_DONE : S_SCAN;
                end
                S_SCAN: begin
                    if (w_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        if (!r_empty && !r_with_repl) begin
                            r_total <= r_total - ACC_W'(r_found_w);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_u   <= i_in_item.uniform_fraction[UNIFORM_BITS-1:0];
            r_k   <= '0;
            r_acc <= '0;
        end
        if ((r_state == S_TOTAL) || (r_state == S_SCAN)) begin
            r_k   <= r_k + CNT_W'(1);
            r_acc <= w_acc_next;
        end
        if (r_state == S_MUL) begin
            r_q     <= w_product[UNIFORM_BITS+ACC_W-1:UNIFORM_BITS];
            r_k     <= '0;
            r_acc   <= '0;
            r_found <= 1'b0;
            r_empty <= (r_total == '0);
        end
        if (w_hit) begin
            r_found   <= 1'b1;
            r_cat     <= CAT_W'(r_k) + CAT_W'(1);
            r_found_w <= w_head;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_item.category   <= r_empty ? '0 : r_cat;
            r_out_item.pool_empty <= r_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `WCS_ASSERT_IMPLY(a_empty_has_no_category, o_out_valid && o_out_item.pool_empty, o_out_item.category == '0)
    `WCS_ASSERT_IMPLY(a_draw_always_hits, (r_state == S_DONE) && !r_empty, r_found)
    `WCS_ASSERT_IMPLY(a_scan_within_total, r_state == S_SCAN, r_acc <= r_total)
endmodule

[bench/weighted_category_sampler_checker.sv]
// Scoreboard for the weighted category sampler: mirrors its state and checks every draw result.
module weighted_category_sampler_checker
    import wcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_draws_pending
);
    localparam int PRINT_LIMIT = 50;
    localparam int PROD_W      = ACC_W + UNIFORM_BITS;

    logic [WEIGHT_BITS-1:0] weight_mem  [MAX_CATEGORIES];
    logic [ACC_W-1:0]       running_sum [MAX_CATEGORIES];
    logic [ACC_W-1:0]       pool_total;
    logic                   sums_dirty;
    logic                   keep_drawn;
    logic [CAT_W-1:0]       count_reg;
    t_out_item              draw_queue [$];
    t_out_item              oldest_draw;
    int                     mismatches = 0;

    function automatic void reset_model();
        for (int k = 0; k < MAX_CATEGORIES; k++) begin
            weight_mem[k]  = '0;
            running_sum[k] = '0;
        end
        pool_total = '0;
        sums_dirty = 1'b0;
        keep_drawn = 1'b1;
        count_reg  = CAT_W'(MAX_CATEGORIES);
        draw_queue.delete();
    endfunction

    // A count above the table size behaves as the full table.
    function automatic int live_slots();
        return (count_reg > MAX_CATEGORIES) ? MAX_CATEGORIES : int'(count_reg);
    endfunction

    function automatic void refresh_sums();
        int               used;
        logic [ACC_W-1:0] acc;
        used = live_slots();
        acc  = '0;
        for (int k = 0; k < MAX_CATEGORIES; k++) begin
            if (k < used) acc += ACC_W'(weight_mem[k]);
            running_sum[k] = (k < used) ? acc : '0;
        end
        pool_total = acc;
        sums_dirty = 1'b0;
    endfunction

    // Inverse-CDF lookup: the first slot whose inclusive sum exceeds floor(u * total).
    function automatic t_out_item draw_sample(logic [UNIFORM_BITS-1:0] u);
        int                used;
        int                lo;
        int                hi;
        int                mid;
        logic [PROD_W-1:0] product;
        logic [ACC_W-1:0]  target;
        t_out_item         result;
        if (sums_dirty) refresh_sums();
        used = live_slots();
        if (used == 0 || pool_total == 0) begin
            result.category   = '0;
            result.pool_empty = 1'b1;
            return result;
        end
        product = PROD_W'(u) * PROD_W'(pool_total);
        target  = ACC_W'(product >> UNIFORM_BITS);
        lo = 0;
        hi = used - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (running_sum[mid] > target) hi = mid;
            else lo = mid + 1;
        end
        result.category   = CAT_W'(lo + 1);
        result.pool_empty = 1'b0;
        if (!keep_drawn) begin
            weight_mem[lo] = '0;
            refresh_sums();
        end
        return result;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: draw result mismatch, %s: got %0d, expected %0d",
                     $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_WITH_REPL) begin
                    keep_drawn = i_cfg_data[0];
                end else if (i_cfg_index == REG_CAT_COUNT) begin
                    count_reg  = i_cfg_data[CAT_W-1:0];
                    sums_dirty = 1'b1;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.func == FUNC_LOAD) begin
                    weight_mem[i_in_item.weight_index] = i_in_item.weight_value;
                    sums_dirty = 1'b1;
                end else begin
                    draw_queue.push_back(draw_sample(i_in_item.uniform_fraction));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (draw_queue.size() == 0) begin
                    flag_mismatch("result with no draw waiting, category",
                                  i_out_item.category, 0);
                end else begin
                    oldest_draw = draw_queue.pop_front();
                    if (i_out_item.category != oldest_draw.category)
                        flag_mismatch("category", i_out_item.category, oldest_draw.category);
                    if (i_out_item.pool_empty != oldest_draw.pool_empty)
                        flag_mismatch("pool_empty", i_out_item.pool_empty,
                                      oldest_draw.pool_empty);
                end
            end
        end
        o_fail_count    <= mismatches;
        o_draws_pending <= draw_queue.size();
    end

endmodule

[bench/weighted_category_sampler_tb.sv]
// Testbench top for the weighted category sampler: clock, reset, item traffic and verdict.
module weighted_category_sampler_tb;
    import wcs_pkg::*;

    localparam int ITEM_TARGET  = 1800;
    localparam int CALM_FROM    = 1600;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD    = 600;
    localparam int HOLD_DRAWS   = 12;
    localparam logic [CFG_IDX_W-1:0]    REG_FIRST_UNUSED = REG_CAT_COUNT + 1'b1;
    localparam logic [CFG_IDX_W-1:0]    REG_LAST_INDEX   = '1;
    localparam logic [UNIFORM_BITS-1:0] U_MAX            = '1;
    localparam logic [WEIGHT_BITS-1:0]  W_MAX            = '1;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  cfg_ready;
    int                    fail_count;
    int                    draws_pending;

    int items_sent    = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    bit sender_gaps   = 1'b0;
    bit receiver_gaps = 1'b0;
    int slots_live    = MAX_CATEGORIES;
    bit keep_mode     = 1'b1;

    weighted_category_sampler uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    weighted_category_sampler_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_item      (out_item),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_draws_pending (draws_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #15_000_000;
        $display("[weighted_category_sampler] ERROR");
        $finish;
    end

    // Valid stays high after an accept; the next call either reloads it or opens a gap.
    task automatic send_item(t_in_item it);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic load_weight(logic [IDX_W-1:0] slot, logic [WEIGHT_BITS-1:0] value);
        t_in_item it;
        it.func             = FUNC_LOAD;
        it.weight_index     = slot;
        it.weight_value     = value;
        it.uniform_fraction = UNIFORM_BITS'($urandom);
        send_item(it);
    endtask

    task automatic request_draw(logic [UNIFORM_BITS-1:0] u);
        t_in_item it;
        it.func             = FUNC_DRAW;
        it.weight_index     = IDX_W'($urandom);
        it.weight_value     = WEIGHT_BITS'($urandom);
        it.uniform_fraction = u;
        send_item(it);
    endtask

    // Loads give no result; settling waits for every pending draw result and then drains.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (draws_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_count(logic [CFG_DATA_W-1:0] value);
        write_reg(REG_CAT_COUNT, value);
        slots_live = (value[CAT_W-1:0] > MAX_CATEGORIES) ? MAX_CATEGORIES
                                                          : int'(value[CAT_W-1:0]);
    endtask

    task automatic set_replacement(logic [CFG_DATA_W-1:0] value);
        write_reg(REG_WITH_REPL, value);
        keep_mode = value[0];
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (holds_done != hold_requests) begin
                holds_done = holds_done + 1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int                    rounds;
        int                    n;
        logic [CFG_DATA_W-1:0] value;
        logic [IDX_W-1:0]      slot;
        logic [WEIGHT_BITS-1:0] wt;
        logic [UNIFORM_BITS-1:0] u;
        rounds = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty pool, extreme slots and fractions, ties, count limits.
        request_draw('0);
        load_weight('0, W_MAX);
        load_weight(IDX_W'(MAX_CATEGORIES - 1), W_MAX);
        load_weight(IDX_W'(5), WEIGHT_BITS'(1));
        request_draw('0);
        request_draw(U_MAX);
        request_draw(UNIFORM_BITS'(16'h8000));
        load_weight(IDX_W'(5), '0);
        set_count('0);
        request_draw(UNIFORM_BITS'(16'h8000));
        set_count(CFG_DATA_W'(1));
        request_draw(U_MAX);
        set_count(CFG_DATA_W'(8'hC8));
        request_draw(UNIFORM_BITS'(16'h8000));
        set_replacement(CFG_DATA_W'(8'hFE));
        request_draw('0);
        request_draw('0);
        request_draw('0);
        write_reg(REG_FIRST_UNUSED, '1);
        write_reg(REG_LAST_INDEX, '1);
        set_replacement(CFG_DATA_W'(8'h01));
        load_weight(IDX_W'(MAX_CATEGORIES - 1), WEIGHT_BITS'(7));
        request_draw('0);
        request_draw(U_MAX);

        // Random part: mostly a batch of loads followed by draws, with some mixed noise.
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= CALM_FROM) begin
                sender_gaps = 1'b0;
                receiver_gaps <= 1'b0;
            end else begin
                sender_gaps = $urandom_range(0, 3) != 0;
                receiver_gaps <= $urandom_range(0, 3) != 0;
            end
            if (rounds % 4 == 3 && items_sent < CALM_FROM) begin
                case ($urandom_range(0, 9))
                    0:       value = CFG_DATA_W'(1);
                    1:       value = CFG_DATA_W'(MAX_CATEGORIES);
                    2:       value = CFG_DATA_W'($urandom_range(MAX_CATEGORIES + 1, 127));
                    3:       value = '0;
                    default: value = CFG_DATA_W'($urandom_range(1, MAX_CATEGORIES));
                endcase
                value[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
                set_count(value);
                set_replacement(CFG_DATA_W'($urandom));
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_INDEX)),
                              CFG_DATA_W'($urandom));
            end
            if (rounds == 5) begin
                // The receiver holds off long enough for the block to back up its input.
                hold_requests <= hold_requests + 1;
                repeat (HOLD_DRAWS) request_draw(UNIFORM_BITS'($urandom));
            end else if (rounds == 10) begin
                settle();
            end
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(4, 12)) begin
                    if ($urandom_range(0, 1) == 0)
                        load_weight(IDX_W'($urandom), WEIGHT_BITS'($urandom));
                    else
                        request_draw(UNIFORM_BITS'($urandom));
                end
            end else begin
                n = (slots_live == 0) ? $urandom_range(1, 4) : $urandom_range(1, slots_live);
                repeat (n) begin
                    slot = (slots_live == 0 || $urandom_range(0, 7) == 0)
                         ? IDX_W'($urandom) : IDX_W'($urandom_range(0, slots_live - 1));
                    case ($urandom_range(0, 7))
                        0:       wt = '0;
                        1:       wt = W_MAX;
                        2, 3:    wt = WEIGHT_BITS'($urandom_range(1, 15));
                        default: wt = WEIGHT_BITS'($urandom);
                    endcase
                    load_weight(slot, wt);
                end
                n = keep_mode ? $urandom_range(1, 10) : $urandom_range(1, slots_live + 2);
                repeat (n) begin
                    case ($urandom_range(0, 7))
                        0:       u = '0;
                        1:       u = U_MAX;
                        default: u = UNIFORM_BITS'($urandom);
                    endcase
                    request_draw(u);
                end
            end
            rounds++;
        end

        settle();
        if (fail_count == 0)
            $display("[weighted_category_sampler] OK");
        else
            $display("[weighted_category_sampler] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/wcs_pkg.sv
hw/rtl/wcs_cell.sv
hw/rtl/wcs_ring.sv
hw/rtl/weighted_category_sampler.sv
bench/weighted_category_sampler_checker.sv
bench/weighted_category_sampler_tb.sv
